FILE: hdl/tak_pkg.sv
package tak_pkg;

  localparam int SQ_STEPS  = 24;
  localparam int CO_STEPS  = 20;
  localparam int DIV_STEPS = 50;

  localparam logic [2:0] CFG_BIAS_ROLL  = 3'd0;
  localparam logic [2:0] CFG_BIAS_PITCH = 3'd1;
  localparam logic [2:0] CFG_STEP_TIME  = 3'd2;
  localparam logic [2:0] CFG_RATE_VAR   = 3'd3;
  localparam logic [2:0] CFG_ANGLE_VAR  = 3'd4;

  localparam logic [15:0] STEP_TIME_RST = 16'd262;
  localparam logic [15:0] RATE_VAR_RST  = 16'd4096;
  localparam logic [15:0] ANGLE_VAR_RST = 16'd2304;
  localparam logic [22:0] VAR_MAX       = 23'd4194304;

  // gyro scale divisor and ceil(2^29 / 131), exact for dividends below 2^21
  localparam logic [7:0]  RATE_DEN      = 8'd131;
  localparam logic [22:0] RECIP_131     = 23'd4098252;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_AA, OP_MUL_BB, OP_SQ_INIT, OP_SQ_STEP, OP_CO_INIT,
    OP_CO_STEP, OP_RATE_INIT, OP_DIV_STEP, OP_RATE_FIN, OP_MUL_DTR, OP_E1,
    OP_MUL_QV, OP_P1, OP_K_FIN, OP_MUL_KD, OP_E2, OP_WB, OP_OUT,
    OP_RATE_MUL, OP_RATE_REM
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       axis;
    logic [5:0] idx;
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_AA, ST_MUL_BB, ST_SQ_INIT, ST_SQ_STEP, ST_CO_INIT, ST_CO_STEP,
    ST_RATE_INIT, ST_RATE_Q1, ST_RATE_REM, ST_RATE_Q2, ST_RATE_FIN, ST_MUL_DTR,
    ST_E1, ST_MUL_QV, ST_P1, ST_K_DIV, ST_K_FIN, ST_MUL_KD, ST_E2, ST_WB,
    ST_FINISH
  } ctrl_state_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117306;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [50:0] rnd_shift(input logic signed [50:0] v,
                                                   input logic [4:0] s);
    logic [50:0] mag;
    logic [50:0] half;
    logic [50:0] q;
    mag  = v[50] ? 51'(-v) : 51'(v);
    half = 51'(1) << (s - 5'd1);
    q    = (mag + half) >> s;
    return v[50] ? -$signed(q) : $signed(q);
  endfunction

endpackage

FILE: hdl/tilt_angle_kalman_filter.sv
// Roll and pitch tilt estimator: one request carries a raw accelerometer and
// gyro sample; the block answers with one result holding the filtered roll
// and pitch angles (degrees, 8 fraction bits) and their variances (20
// fraction bits). Each request runs one restoring divider for the gain,
// shared by both axes, a 24-step square root and a 20-step CORDIC, all run
// once per axis in turn; the gyro scaling is a reciprocal multiply. No new
// request is accepted until the current result is in the output register.
// in_ready is high only while idle; a finished result waits in the output
// register while the next request is accepted, and the block stalls before
// its next result until that register is taken. Configuration writes take
// effect at once; the user must make them only while the block is idle, as
// the block itself does not enforce this.
module tilt_angle_kalman_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_roll,
  input  logic signed [15:0] in_gyro_pitch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic [22:0]        out_roll_uncertainty,
  output logic [22:0]        out_pitch_uncertainty,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_wr_data
);

  tak_pkg::dp_cmd_t cmd;

  tak_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tak_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wr_data           (cfg_wr_data),
    .in_accel_x            (in_accel_x),
    .in_accel_y            (in_accel_y),
    .in_accel_z            (in_accel_z),
    .in_gyro_roll          (in_gyro_roll),
    .in_gyro_pitch         (in_gyro_pitch),
    .out_roll_angle        (out_roll_angle),
    .out_pitch_angle       (out_pitch_angle),
    .out_roll_uncertainty  (out_roll_uncertainty),
    .out_pitch_uncertainty (out_pitch_uncertainty)
  );

endmodule

FILE: hdl/tak_ctrl.sv
module tak_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output tak_pkg::dp_cmd_t cmd
);

  tak_pkg::ctrl_state_t state_r, state_nxt;
  logic       axis_r, axis_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tak_pkg::ST_IDLE;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cnt_nxt       = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = tak_pkg::OP_NONE;
    cmd.axis      = axis_r;
    cmd.idx       = cnt_r;
    in_ready      = 1'b0;
    case (state_r)
      tak_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = tak_pkg::OP_LOAD;
          axis_nxt  = 1'b0;
          state_nxt = tak_pkg::ST_MUL_AA;
        end
      end
      tak_pkg::ST_MUL_AA: begin
        cmd.op = tak_pkg::OP_MUL_AA;
        state_nxt = tak_pkg::ST_MUL_BB;
      end
      tak_pkg::ST_MUL_BB: begin
        cmd.op = tak_pkg::OP_MUL_BB;
        state_nxt = tak_pkg::ST_SQ_INIT;
      end
      tak_pkg::ST_SQ_INIT: begin
        cmd.op = tak_pkg::OP_SQ_INIT;
        state_nxt = tak_pkg::ST_SQ_STEP;
      end
      tak_pkg::ST_SQ_STEP: begin
        cmd.op = tak_pkg::OP_SQ_STEP;
        if (cnt_r == 6'(tak_pkg::SQ_STEPS - 1)) begin
          state_nxt = tak_pkg::ST_CO_INIT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      tak_pkg::ST_CO_INIT: begin
        cmd.op = tak_pkg::OP_CO_INIT;
        state_nxt = tak_pkg::ST_CO_STEP;
      end
      tak_pkg::ST_CO_STEP: begin
        cmd.op = tak_pkg::OP_CO_STEP;
        if (cnt_r == 6'(tak_pkg::CO_STEPS - 1)) begin
          state_nxt = tak_pkg::ST_RATE_INIT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      tak_pkg::ST_RATE_INIT: begin
        cmd.op = tak_pkg::OP_RATE_INIT;
        state_nxt = tak_pkg::ST_RATE_Q1;
      end
      tak_pkg::ST_RATE_Q1: begin
        cmd.op = tak_pkg::OP_RATE_MUL;
        state_nxt = tak_pkg::ST_RATE_REM;
      end
      tak_pkg::ST_RATE_REM: begin
        cmd.op = tak_pkg::OP_RATE_REM;
        state_nxt = tak_pkg::ST_RATE_Q2;
      end
      tak_pkg::ST_RATE_Q2: begin
        cmd.op = tak_pkg::OP_RATE_MUL;
        state_nxt = tak_pkg::ST_RATE_FIN;
      end
      tak_pkg::ST_RATE_FIN: begin
        cmd.op = tak_pkg::OP_RATE_FIN;
        state_nxt = tak_pkg::ST_MUL_DTR;
      end
      tak_pkg::ST_MUL_DTR: begin
        cmd.op = tak_pkg::OP_MUL_DTR;
        state_nxt = tak_pkg::ST_E1;
      end
      tak_pkg::ST_E1: begin
        cmd.op = tak_pkg::OP_E1;
        state_nxt = tak_pkg::ST_MUL_QV;
      end
      tak_pkg::ST_MUL_QV: begin
        cmd.op = tak_pkg::OP_MUL_QV;
        state_nxt = tak_pkg::ST_P1;
      end
      tak_pkg::ST_P1: begin
        cmd.op = tak_pkg::OP_P1;
        state_nxt = tak_pkg::ST_K_DIV;
      end
      tak_pkg::ST_K_DIV: begin
        cmd.op = tak_pkg::OP_DIV_STEP;
        if (cnt_r == 6'(tak_pkg::DIV_STEPS - 1)) begin
          state_nxt = tak_pkg::ST_K_FIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      tak_pkg::ST_K_FIN: begin
        cmd.op = tak_pkg::OP_K_FIN;
        state_nxt = tak_pkg::ST_MUL_KD;
      end
      tak_pkg::ST_MUL_KD: begin
        cmd.op = tak_pkg::OP_MUL_KD;
        state_nxt = tak_pkg::ST_E2;
      end
      tak_pkg::ST_E2: begin
        cmd.op = tak_pkg::OP_E2;
        state_nxt = tak_pkg::ST_WB;
      end
      tak_pkg::ST_WB: begin
        cmd.op = tak_pkg::OP_WB;
        if (axis_r) begin
          state_nxt = tak_pkg::ST_FINISH;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = tak_pkg::ST_MUL_AA;
        end
      end
      tak_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = tak_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = tak_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tak_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/tak_dp.sv
module tak_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tak_pkg::dp_cmd_t    cmd,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [19:0]         cfg_wr_data,
  input  logic signed [15:0]  in_accel_x,
  input  logic signed [15:0]  in_accel_y,
  input  logic signed [15:0]  in_accel_z,
  input  logic signed [15:0]  in_gyro_roll,
  input  logic signed [15:0]  in_gyro_pitch,
  output logic signed [15:0]  out_roll_angle,
  output logic signed [15:0]  out_pitch_angle,
  output logic [22:0]         out_roll_uncertainty,
  output logic [22:0]         out_pitch_uncertainty
);

  localparam logic signed [50:0] VAR_MAX_S = 51'(tak_pkg::VAR_MAX);

  logic signed [19:0] bias_r [2];
  logic [15:0] dt_r, qv_r, rv_r;

  logic signed [15:0] ax_r, ay_r, az_r, gr_r, gp_r;
  logic signed [24:0] est_r [2];
  logic [22:0]        var_r [2];

  logic signed [50:0] prod_r;
  logic [31:0]        sq_r;
  logic [47:0]        rad_r, res_r, bit_r;
  logic signed [26:0] cx_r, cy_r;
  logic signed [24:0] cz_r;
  logic               czero_r;
  logic signed [24:0] m_r;
  logic [49:0]        dnum_r;
  logic [29:0]        drem_r, dden_r;
  logic               dneg_r;
  logic [20:0]        rg_r;
  logic [12:0]        rq_r;
  logic signed [27:0] rate_r;
  logic signed [29:0] e_r;
  logic [28:0]        p_r;
  logic [20:0]        k_r;
  logic signed [15:0] oroll_r, opitch_r;
  logic [22:0]        ovr_r, ovp_r;

  logic signed [15:0] t_num, t_a, t_b, g_sel;
  logic signed [19:0] b_sel;
  logic signed [33:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [64:0] mul_full;
  logic signed [29:0] diff;
  logic [47:0]        sq_trial;
  logic signed [26:0] sx, sy;
  logic signed [24:0] atan_v;
  logic signed [20:0] g_diff;
  logic [12:0]        q_part;
  logic [20:0]        q_rem;
  logic [30:0]        d_trial;
  logic               d_ge;
  logic [27:0]        r_q;
  logic signed [50:0] r16, r20;
  logic [28:0]        p1;
  logic [15:0]        rv_eff;
  logic [29:0]        k_den;
  logic signed [29:0] e_sat;
  logic signed [50:0] p_new;
  logic [22:0]        p_sat;
  logic signed [50:0] ar, ap;

  function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
    logic signed [15:0] s;
    if (v > 51'sd32767) begin
      s = 16'sh7fff;
    end else if (v < -51'sd32768) begin
      s = -16'sh8000;
    end else begin
      s = v[15:0];
    end
    return s;
  endfunction

  always_comb begin
    t_num = cmd.axis ? ax_r : ay_r;
    t_a   = cmd.axis ? ay_r : ax_r;
    t_b   = az_r;
    g_sel = cmd.axis ? gp_r : gr_r;
    b_sel = bias_r[cmd.axis];
    diff  = 30'(m_r) - e_r;
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      tak_pkg::OP_MUL_AA: begin
        mul_a = 34'(t_a);
        mul_b = 31'(t_a);
      end
      tak_pkg::OP_MUL_BB: begin
        mul_a = 34'(t_b);
        mul_b = 31'(t_b);
      end
      tak_pkg::OP_RATE_MUL: begin
        mul_a = $signed({13'd0, rg_r});
        mul_b = $signed({8'd0, tak_pkg::RECIP_131});
      end
      tak_pkg::OP_MUL_DTR: begin
        mul_a = 34'(rate_r);
        mul_b = $signed({15'd0, dt_r});
      end
      tak_pkg::OP_E1: begin
        mul_a = $signed({18'd0, dt_r});
        mul_b = $signed({15'd0, dt_r});
      end
      tak_pkg::OP_MUL_QV: begin
        mul_a = $signed({2'd0, prod_r[31:0]});
        mul_b = $signed({15'd0, qv_r});
      end
      tak_pkg::OP_MUL_KD: begin
        mul_a = 34'(diff);
        mul_b = $signed({10'd0, k_r});
      end
      tak_pkg::OP_E2: begin
        mul_a = $signed({5'd0, p_r});
        mul_b = $signed({10'd0, 21'(21'd1048576 - k_r)});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign sq_trial = res_r + bit_r;
  assign sx       = cx_r >>> cmd.idx[4:0];
  assign sy       = cy_r >>> cmd.idx[4:0];
  assign atan_v   = $signed({3'd0, tak_pkg::atan_q16(cmd.idx[4:0])});

  assign g_diff = $signed({g_sel, 4'd0}) - 21'(b_sel);

  assign q_part = prod_r[41:29];
  assign q_rem  = rg_r - 21'(q_part) * 21'(tak_pkg::RATE_DEN);
  assign r_q    = {2'd0, rq_r, 13'd0} + {15'd0, q_part};

  assign d_trial = {drem_r, dnum_r[49]};
  assign d_ge    = d_trial >= {1'b0, dden_r};

  assign r16    = tak_pkg::rnd_shift(prod_r, 5'd16);
  assign r20    = tak_pkg::rnd_shift(prod_r, 5'd20);
  assign p1     = 29'(var_r[cmd.axis]) + r20[28:0];
  assign rv_eff = (rv_r == 16'd0) ? 16'd1 : rv_r;
  assign k_den  = 30'(p1) + {2'd0, rv_eff, 12'd0};

  always_comb begin
    if (e_r > 30'sd16777215) begin
      e_sat = 30'sd16777215;
    end else if (e_r < -30'sd16777216) begin
      e_sat = -30'sd16777216;
    end else begin
      e_sat = e_r;
    end
  end

  assign p_new = r20;
  assign p_sat = (p_new > VAR_MAX_S) ? tak_pkg::VAR_MAX : p_new[22:0];

  assign ar = tak_pkg::rnd_shift(51'(est_r[0]), 5'd8);
  assign ap = tak_pkg::rnd_shift(51'(est_r[1]), 5'd8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r[0] <= '0;
      bias_r[1] <= '0;
      dt_r      <= tak_pkg::STEP_TIME_RST;
      qv_r      <= tak_pkg::RATE_VAR_RST;
      rv_r      <= tak_pkg::ANGLE_VAR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tak_pkg::CFG_BIAS_ROLL:  bias_r[0] <= cfg_wr_data;
        tak_pkg::CFG_BIAS_PITCH: bias_r[1] <= cfg_wr_data;
        tak_pkg::CFG_STEP_TIME:  dt_r      <= cfg_wr_data[15:0];
        tak_pkg::CFG_RATE_VAR:   qv_r      <= cfg_wr_data[15:0];
        tak_pkg::CFG_ANGLE_VAR:  rv_r      <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r[0] <= '0;
      est_r[1] <= '0;
      var_r[0] <= tak_pkg::VAR_MAX;
      var_r[1] <= tak_pkg::VAR_MAX;
    end else if (cmd.op == tak_pkg::OP_WB) begin
      est_r[cmd.axis] <= e_sat[24:0];
      var_r[cmd.axis] <= p_sat;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tak_pkg::OP_MUL_AA, tak_pkg::OP_MUL_DTR, tak_pkg::OP_MUL_QV,
      tak_pkg::OP_MUL_KD, tak_pkg::OP_RATE_MUL: begin
        prod_r <= mul_full[50:0];
      end
      tak_pkg::OP_LOAD: begin
        ax_r <= in_accel_x;
        ay_r <= in_accel_y;
        az_r <= in_accel_z;
        gr_r <= in_gyro_roll;
        gp_r <= in_gyro_pitch;
      end
      tak_pkg::OP_MUL_BB: begin
        sq_r   <= prod_r[31:0];
        prod_r <= mul_full[50:0];
      end
      tak_pkg::OP_SQ_INIT: begin
        rad_r <= {(sq_r + prod_r[31:0]), 16'd0};
        res_r <= '0;
        bit_r <= 48'd1 << 46;
      end
      tak_pkg::OP_SQ_STEP: begin
        if (rad_r >= sq_trial) begin
          rad_r <= rad_r - sq_trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      tak_pkg::OP_CO_INIT: begin
        cx_r    <= $signed({3'd0, res_r[23:0]});
        cy_r    <= 27'(t_num) <<< 8;
        cz_r    <= '0;
        czero_r <= (res_r == 48'd0) || (t_num == 16'sd0);
      end
      tak_pkg::OP_CO_STEP: begin
        if (cy_r > 27'sd0) begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          cz_r <= cz_r + atan_v;
        end else begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          cz_r <= cz_r - atan_v;
        end
      end
      tak_pkg::OP_RATE_INIT: begin
        m_r    <= czero_r ? 25'sd0 : (cmd.axis ? -cz_r : cz_r);
        rg_r   <= g_diff[20] ? 21'(-g_diff) : 21'(g_diff);
        dneg_r <= g_diff[20];
      end
      tak_pkg::OP_RATE_REM: begin
        rq_r <= q_part;
        rg_r <= {q_rem[7:0], 13'd0} + 21'(tak_pkg::RATE_DEN >> 1);
      end
      tak_pkg::OP_DIV_STEP: begin
        drem_r <= d_ge ? 30'(d_trial - {1'b0, dden_r}) : d_trial[29:0];
        dnum_r <= {dnum_r[48:0], d_ge};
      end
      tak_pkg::OP_RATE_FIN: begin
        rate_r <= dneg_r ? -$signed(r_q) : $signed(r_q);
      end
      tak_pkg::OP_E1: begin
        e_r    <= 30'(est_r[cmd.axis]) + r16[29:0];
        prod_r <= mul_full[50:0];
      end
      tak_pkg::OP_P1: begin
        p_r    <= p1;
        dden_r <= k_den;
        dnum_r <= ({21'd0, p1} << 20) + 50'(k_den >> 1);
        drem_r <= '0;
        dneg_r <= 1'b0;
      end
      tak_pkg::OP_K_FIN: begin
        k_r <= dnum_r[20:0];
      end
      tak_pkg::OP_E2: begin
        e_r    <= e_r + r20[29:0];
        prod_r <= mul_full[50:0];
      end
      tak_pkg::OP_OUT: begin
        oroll_r  <= sat16(ar);
        opitch_r <= sat16(ap);
        ovr_r    <= var_r[0];
        ovp_r    <= var_r[1];
      end
      default: ;
    endcase
  end

  assign out_roll_angle        = oroll_r;
  assign out_pitch_angle       = opitch_r;
  assign out_roll_uncertainty  = ovr_r;
  assign out_pitch_uncertainty = ovp_r;

endmodule
